/* hdl/infix_to_prefix_operator_stack_core_assert.svh */
// Assertion macros for the operator stack core engine.
// Expects clk and rst_n in the scope of each use.
`ifndef INFIX_TO_PREFIX_OPERATOR_STACK_CORE_ASSERT_SVH
`define INFIX_TO_PREFIX_OPERATOR_STACK_CORE_ASSERT_SVH

// Same-cycle implication.
`define ITPS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/itps_pkg.sv */
// Package for the infix-to-prefix operator stack core.
// Character codes, command and state types, precedence helpers; no dependencies.
`timescale 1ns / 1ps

package itps_pkg;

  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNMATCH  = 2'd2;

  localparam logic [1:0] RANK_POW = 2'd3;
  localparam logic [1:0] RANK_MUL = 2'd2;
  localparam logic [1:0] RANK_ADD = 2'd1;
  localparam logic [1:0] RANK_LOW = 2'd0;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef enum logic [1:0] {
    K_OPERAND,
    K_OPEN,
    K_CLOSE,
    K_OPER
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] rank;
    logic       is_pow;
    logic [7:0] sym;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPPOP,
    S_CLPOP,
    S_FLUSH,
    S_FINISH
  } eng_state_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    case (ch) inside
      CH_POW:                 r = RANK_POW;
      CH_MUL, CH_DIV, CH_MOD: r = RANK_MUL;
      CH_ADD, CH_SUB:         r = RANK_ADD;
      default:                r = RANK_LOW;
    endcase
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] ch);
    return ch inside {[CH_DIG0:CH_DIG9], [CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
  endfunction

endpackage

/* hdl/itps_front.sv */
// Front end: accepts input characters and classifies them into commands.
// Depends on itps_pkg; feeds itps_cmd_fifo.
`timescale 1ns / 1ps

module itps_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] symbol
  input  logic              in_tlast,   // end_of_expression
  input  logic              q_full,
  output logic              q_push,
  output itps_pkg::cmd_t    q_cmd
);
  import itps_pkg::*;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.sym    = in_tdata;
    q_cmd.last   = in_tlast;
    q_cmd.rank   = rank_of(in_tdata);
    q_cmd.is_pow = (in_tdata == CH_POW);
    if (is_operand(in_tdata)) begin
      q_cmd.kind = K_OPERAND;
    end else if (in_tdata == CH_OPEN) begin
      q_cmd.kind = K_OPEN;
    end else if (in_tdata == CH_CLOSE) begin
      q_cmd.kind = K_CLOSE;
    end else begin
      q_cmd.kind = K_OPER;
    end
  end

endmodule

/* hdl/itps_cmd_fifo.sv */
// Two-entry command queue between the front end and the stack engine.
// Depends on itps_pkg.
`timescale 1ns / 1ps

module itps_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itps_pkg::cmd_t  push_cmd,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output itps_pkg::cmd_t  pop_cmd
);
  import itps_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/itps_engine.sv */
// Back end: stack engine and output register; one push or pop per unstalled cycle.
// Depends on itps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "infix_to_prefix_operator_stack_core_assert.svh"

module itps_engine #(
  parameter int STACK_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  itps_pkg::cmd_t  q_cmd,
  output logic            q_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,  // [7:0] emitted_symbol, [8] expression_done
  output logic            out_tlast,  // last_of_run
  output logic [2:0]      out_tuser   // [0] symbol_valid, [2:1] status
);
  import itps_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [7:0]    rd_data_r;

  eng_state_t    state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] open_cnt_r, open_cnt_nxt;
  logic [7:0]    top_r, top_nxt;
  logic          fresh_r, fresh_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [7:0]    held_sym_r, held_sym_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_sym_r, out_sym_nxt;
  logic          out_symv_r, out_symv_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_done_r, out_done_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;

  logic          out_free;
  logic [7:0]    top_sel;
  logic          nonempty, full_stk;
  logic          do_pop, do_push, emit, finish;
  logic [7:0]    push_sym, emit_sym;
  logic [CW-1:0] cnt_m2;
  logic [IW-1:0] rd_addr;

  function automatic logic pops_top(input logic [1:0] r, input logic pw,
                                    input logic [7:0] top);
    logic [1:0] tr;
    tr = rank_of(top);
    return (r < tr) || ((r == tr) && pw);
  endfunction

  assign out_free = !out_valid_r || out_tready;
  assign top_sel  = fresh_r ? rd_data_r : top_r;
  assign nonempty = (count_r != '0);
  assign full_stk = (count_r == DEPTH_C);
  assign cnt_m2   = count_r - CW'(2);
  assign rd_addr  = cnt_m2[IW-1:0];

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_sym   = cmd_r.sym;
    emit       = 1'b0;
    emit_sym   = top_sel;
    finish     = 1'b0;
    q_ready    = 1'b0;
    if (out_free) begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            q_ready    = 1'b1;
            cmd_nxt    = q_cmd;
            status_nxt = ST_OK;
            case (q_cmd.kind)
              K_OPERAND: begin
                emit      = 1'b1;
                emit_sym  = q_cmd.sym;
                state_nxt = q_cmd.last ? S_FLUSH : S_FINISH;
              end
              K_OPEN: begin
                if (full_stk) begin
                  status_nxt = ST_OVERFLOW;
                end else begin
                  do_push  = 1'b1;
                  push_sym = q_cmd.sym;
                end
                state_nxt = q_cmd.last ? S_FLUSH : S_FINISH;
              end
              K_CLOSE: begin
                if (open_cnt_r == '0) status_nxt = ST_UNMATCH;
                state_nxt = S_CLPOP;
              end
              default: begin
                if (full_stk && !(nonempty && pops_top(q_cmd.rank, q_cmd.is_pow, top_sel)))
                  status_nxt = ST_OVERFLOW;
                state_nxt = S_OPPOP;
              end
            endcase
          end
        end
        S_OPPOP: begin
          if (nonempty && pops_top(cmd_r.rank, cmd_r.is_pow, top_sel)) begin
            emit   = 1'b1;
            do_pop = 1'b1;
          end else begin
            do_push   = !full_stk;
            state_nxt = cmd_r.last ? S_FLUSH : S_FINISH;
          end
        end
        S_CLPOP: begin
          if (nonempty) begin
            do_pop = 1'b1;
            if (top_sel == CH_OPEN) begin
              state_nxt = cmd_r.last ? S_FLUSH : S_FINISH;
            end else begin
              emit = 1'b1;
            end
          end else begin
            state_nxt = cmd_r.last ? S_FLUSH : S_FINISH;
          end
        end
        S_FLUSH: begin
          if (nonempty) begin
            emit   = 1'b1;
            do_pop = 1'b1;
          end else begin
            state_nxt = S_FINISH;
          end
        end
        S_FINISH: begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    count_nxt    = count_r;
    open_cnt_nxt = open_cnt_r;
    top_nxt      = top_sel;
    fresh_nxt    = 1'b0;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = push_sym;
      if (push_sym == CH_OPEN) open_cnt_nxt = open_cnt_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
      fresh_nxt = 1'b1;
      if (top_sel == CH_OPEN) open_cnt_nxt = open_cnt_r - CW'(1);
    end
  end

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_sym_nxt   = held_sym_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sym_nxt    = out_sym_r;
    out_symv_nxt   = out_symv_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_stat_nxt   = out_stat_r;
    if (emit) begin
      held_valid_nxt = 1'b1;
      held_sym_nxt   = emit_sym;
      if (held_valid_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = held_sym_r;
        out_symv_nxt  = 1'b1;
        out_last_nxt  = 1'b0;
        out_done_nxt  = 1'b0;
        out_stat_nxt  = status_r;
      end
    end else if (finish) begin
      held_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_sym_nxt    = held_valid_r ? held_sym_r : 8'h00;
      out_symv_nxt   = held_valid_r;
      out_last_nxt   = 1'b1;
      out_done_nxt   = cmd_r.last;
      out_stat_nxt   = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      open_cnt_r   <= '0;
      fresh_r      <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      open_cnt_r   <= open_cnt_nxt;
      fresh_r      <= fresh_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    top_r      <= top_nxt;
    held_sym_r <= held_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_symv_r <= out_symv_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[count_r[IW-1:0]] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_done_r, out_sym_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_stat_r, out_symv_r};

  `ITPS_ASSERT_HOLDS(a_count_range, 1'b1, count_r <= DEPTH_C, "stack count beyond depth")
  `ITPS_ASSERT_HOLDS(a_open_bound, 1'b1, open_cnt_r <= count_r, "open count exceeds stack count")
  `ITPS_ASSERT_HOLDS(a_push_room, do_push, !full_stk && !do_pop, "push onto full stack")
  `ITPS_ASSERT_NEXT(a_finish_out, (state_r == S_FINISH) && out_free, out_valid_r && out_last_r && !held_valid_r, "finish did not close run")

endmodule

/* hdl/infix_to_prefix_operator_stack_core.sv */
// Flow: an operand goes through the command queue and held-symbol register, entering the
// output register at the next emit or finish. Items leave S_IDLE for S_FINISH, via S_OPPOP
// or S_CLPOP for operators and closes and S_FLUSH at end of expression; new items wait in S_IDLE.
// Reset: synchronous active-low rst_n clears queue, stack count and output valid;
// stack memory contents are not cleared.
// Top level of the operator stack core; depends on itps_pkg, front, queue, engine.
`timescale 1ns / 1ps

module infix_to_prefix_operator_stack_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // end_of_expression
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] emitted_symbol, [8] expression_done, [15:9] zero
  output logic        out_tlast,  // last_of_run
  output logic [2:0]  out_tuser   // [0] symbol_valid, [2:1] status
);
  import itps_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic q_push, q_full, q_valid, q_ready;

  itps_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (front_cmd)
  );

  itps_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_ready),
    .pop_cmd   (head_cmd)
  );

  itps_engine #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
